[hw/rtl/efa_pkg.sv]
`default_nettype none

package efa_pkg;

   localparam int TS_W   = 31;
   localparam int CNT_W  = 16;
   localparam int SUM_W  = 48;
   localparam int MEAN_W = 32;
   localparam int CSR_W  = 8;
   // One store word: time sum on top, negative count, positive count at the bottom.
   localparam int WORD_W = SUM_W + 2 * CNT_W;

   localparam logic [1:0] CMD_ACCUM = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [2:0] STATUS_ACCEPTED      = 3'd0;
   localparam logic [2:0] STATUS_OUT_OF_BOUNDS = 3'd1;
   localparam logic [2:0] STATUS_SATURATED     = 3'd2;
   localparam logic [2:0] STATUS_PIXEL         = 3'd3;
   localparam logic [2:0] STATUS_CLEARED       = 3'd4;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [CSR_W-1:0] FRAME_SIZE_RESET = 8'd128;
   localparam logic [CNT_W:0]   COUNT_LIMIT      = 17'd65535;

   typedef enum logic [1:0] {
      OP_ACCUM,
      OP_READ,
      OP_CLEAR
   } op_kind_type;

   typedef struct packed {
      op_kind_type      kind;
      logic             out_of_bounds;
      logic             polarity;
      logic [TS_W-1:0]  timestamp;
   } op_info_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC,
      BK_DIV,
      BK_POST
   } back_state_type;

endpackage

`default_nettype wire

[hw/rtl/efa_ram.sv]
`default_nettype none

module efa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/efa_fifo.sv]
`default_nettype none

module efa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output logic      [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   assign full     = (count_ff == (PW + 1)'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/efa_front.sv]
`default_nettype none

module efa_front
   import efa_pkg::*;
#(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT,
   localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_command,
   input  wire logic [TS_W-1:0]   req_timestamp,
   input  wire logic [7:0]        req_x_coord,
   input  wire logic [7:0]        req_y_coord,
   input  wire logic              req_polarity,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_index,
   input  wire logic [CSR_W-1:0]  csr_write_data,
   input  wire logic              sweeping,
   input  wire logic              fifo_full,
   output logic                   push,
   output op_info_type            push_info,
   output logic      [AW-1:0]     push_addr
);

   logic [CSR_W-1:0] frame_width_ff, frame_width_in;
   logic [CSR_W-1:0] frame_height_ff, frame_height_in;
   logic             hold_valid_ff, hold_valid_in;
   op_info_type      hold_info_ff, hold_info_in;
   logic [AW-1:0]    hold_addr_ff, hold_addr_in;

   logic             accept;
   logic             keep;
   op_kind_type      kind;
   logic             x_ok;
   logic             y_ok;
   logic [AW-1:0]    entry;

   assign req_stall = sweeping || (hold_valid_ff && fifo_full);
   assign accept    = req_valid && !req_stall;
   assign push      = hold_valid_ff && !fifo_full;
   assign push_info = hold_info_ff;
   assign push_addr = hold_addr_ff;

   // Command 3 is taken off the channel and dropped here.
   always_comb begin
      keep = 1'b1;
      kind = OP_ACCUM;
      unique case (req_command)
         CMD_ACCUM: kind = OP_ACCUM;
         CMD_READ:  kind = OP_READ;
         CMD_CLEAR: kind = OP_CLEAR;
         default:   keep = 1'b0;
      endcase
   end

   // Checking against both the register and the build size acts as the clamp.
   assign x_ok  = (req_x_coord < frame_width_ff) && (32'(req_x_coord) < MAX_WIDTH);
   assign y_ok  = (req_y_coord < frame_height_ff) && (32'(req_y_coord) < MAX_HEIGHT);
   assign entry = AW'(AW'(req_y_coord) * AW'(MAX_WIDTH)) + AW'(req_x_coord);

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_write_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_write_data;
            default:          frame_width_in  = frame_width_ff;
         endcase
      end
   end

   always_comb begin
      hold_info_in = hold_info_ff;
      hold_addr_in = hold_addr_ff;
      if (accept && keep) begin
         hold_valid_in = 1'b1;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
      if (accept) begin
         hold_info_in.kind          = kind;
         hold_info_in.out_of_bounds = !(x_ok && y_ok);
         hold_info_in.polarity      = req_polarity;
         hold_info_in.timestamp     = req_timestamp;
         hold_addr_in               = entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_SIZE_RESET;
         frame_height_ff <= FRAME_SIZE_RESET;
         hold_valid_ff   <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         hold_valid_ff   <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_info_ff <= hold_info_in;
      hold_addr_ff <= hold_addr_in;
   end

endmodule

`default_nettype wire

[hw/rtl/efa_div.sv]
`default_nettype none

module efa_div
   import efa_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [SUM_W-1:0]  dividend,
   input  wire logic        [CNT_W-1:0]  divisor,
   output logic                          done,
   output logic signed      [MEAN_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  divisor_ff, divisor_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;

   logic [SUM_W-1:0]  magnitude;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              fits;

   assign magnitude = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
   assign trial     = {rem_ff, quo_ff[SUM_W-1]};
   assign diff      = trial - {1'b0, divisor_ff};
   assign fits      = (trial >= {1'b0, divisor_ff});

   // Restoring division, one quotient bit per cycle; the sign is put back at the end.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      neg_in     = neg_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         neg_in     = dividend[SUM_W-1];
         divisor_in = divisor;
         rem_in     = '0;
         quo_in     = magnitude;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? $signed(~quo_ff[MEAN_W-1:0] + 1'b1)
                            : $signed(quo_ff[MEAN_W-1:0]);

endmodule

`default_nettype wire

[hw/rtl/efa_back.sv]
`default_nettype none

module efa_back
   import efa_pkg::*;
#(
   parameter int PIXELS = 16384,
   localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fifo_valid,
   input  wire op_info_type              fifo_info,
   input  wire logic        [AW-1:0]     fifo_addr,
   output logic                          fifo_pop,
   output logic                          sweeping,
   output logic                          ram_rd_en,
   output logic             [AW-1:0]     ram_rd_addr,
   input  wire logic        [WORD_W-1:0] ram_rd_data,
   output logic                          ram_wr_en,
   output logic             [AW-1:0]     ram_wr_addr,
   output logic             [WORD_W-1:0] ram_wr_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic             [2:0]        rsp_status,
   output logic             [CNT_W-1:0]  rsp_positive_count,
   output logic             [CNT_W-1:0]  rsp_negative_count,
   output logic signed      [MEAN_W-1:0] rsp_mean_time
);

   back_state_type           state_ff, state_in;
   logic [AW-1:0]            clr_addr_ff, clr_addr_in;
   logic                     clr_reply_ff, clr_reply_in;
   logic [TS_W-1:0]          ref_time_ff, ref_time_in;
   logic                     ref_taken_ff, ref_taken_in;
   op_info_type              cur_info_ff, cur_info_in;
   logic [AW-1:0]            cur_addr_ff, cur_addr_in;
   logic [2:0]               res_status_ff, res_status_in;
   logic [CNT_W-1:0]         res_pos_ff, res_pos_in;
   logic [CNT_W-1:0]         res_neg_ff, res_neg_in;
   logic signed [MEAN_W-1:0] res_mean_ff, res_mean_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0]               rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic [CNT_W-1:0]         rsp_neg_ff, rsp_neg_in;
   logic signed [MEAN_W-1:0] rsp_mean_ff, rsp_mean_in;

   logic                     out_free;
   logic                     rsp_load;
   logic [2:0]               ld_status;
   logic [CNT_W-1:0]         ld_pos;
   logic [CNT_W-1:0]         ld_neg;
   logic signed [MEAN_W-1:0] ld_mean;
   logic                     clr_last;

   logic [CNT_W-1:0]         word_pos;
   logic [CNT_W-1:0]         word_neg;
   logic signed [SUM_W-1:0]  word_sum;
   logic [CNT_W:0]           total;
   logic                     saturated;
   logic signed [TS_W:0]     offset;
   logic signed [SUM_W-1:0]  new_sum;
   logic [CNT_W-1:0]         new_pos;
   logic [CNT_W-1:0]         new_neg;

   logic                     div_start;
   logic                     div_done;
   logic signed [MEAN_W-1:0] div_quotient;

   assign word_pos  = ram_rd_data[CNT_W-1:0];
   assign word_neg  = ram_rd_data[2*CNT_W-1:CNT_W];
   assign word_sum  = $signed(ram_rd_data[WORD_W-1:2*CNT_W]);
   assign total     = {1'b0, word_pos} + {1'b0, word_neg};
   assign saturated = (total >= COUNT_LIMIT);
   assign offset    = $signed({1'b0, cur_info_ff.timestamp}) - $signed({1'b0, ref_time_ff});
   assign new_sum   = word_sum + SUM_W'(offset);
   assign new_pos   = cur_info_ff.polarity ? word_pos + 1'b1 : word_pos;
   assign new_neg   = cur_info_ff.polarity ? word_neg : word_neg + 1'b1;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign clr_last    = (clr_addr_ff == AW'(PIXELS - 1));
   assign sweeping    = (state_ff == BK_CLEAR);
   assign ram_rd_addr = fifo_addr;

   efa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (word_sum),
      .divisor  (total[CNT_W-1:0]),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_last) begin
               state_in = clr_reply_ff ? BK_POST : BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (fifo_valid) begin
               priority if (fifo_info.kind == OP_CLEAR) begin
                  state_in = BK_CLEAR;
               end else if (fifo_info.out_of_bounds) begin
                  state_in = BK_POST;
               end else begin
                  state_in = BK_EXEC;
               end
            end
         end
         BK_EXEC: begin
            if (cur_info_ff.kind == OP_READ && total != '0) begin
               state_in = BK_DIV;
            end else if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_DIV: begin
            if (div_done) begin
               state_in = BK_POST;
            end
         end
         BK_POST: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   always_comb begin
      fifo_pop      = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_addr_ff;
      ram_wr_data   = {new_sum, new_neg, new_pos};
      div_start     = 1'b0;
      rsp_load      = 1'b0;
      ld_status     = res_status_ff;
      ld_pos        = res_pos_ff;
      ld_neg        = res_neg_ff;
      ld_mean       = res_mean_ff;
      clr_addr_in   = clr_addr_ff;
      clr_reply_in  = clr_reply_ff;
      ref_time_in   = ref_time_ff;
      ref_taken_in  = ref_taken_ff;
      cur_info_in   = cur_info_ff;
      cur_addr_in   = cur_addr_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_neg_in    = res_neg_ff;
      res_mean_in   = res_mean_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            if (clr_last) begin
               clr_addr_in  = '0;
               clr_reply_in = 1'b0;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (fifo_valid) begin
               fifo_pop    = 1'b1;
               cur_info_in = fifo_info;
               cur_addr_in = fifo_addr;
               res_pos_in  = '0;
               res_neg_in  = '0;
               res_mean_in = '0;
               if (fifo_info.kind == OP_CLEAR) begin
                  clr_reply_in  = 1'b1;
                  ref_time_in   = '0;
                  ref_taken_in  = 1'b0;
                  res_status_in = STATUS_CLEARED;
               end else begin
                  // The first event after a clear fixes the reference, even if dropped.
                  if (fifo_info.kind == OP_ACCUM && !ref_taken_ff) begin
                     ref_time_in  = fifo_info.timestamp;
                     ref_taken_in = 1'b1;
                  end
                  if (fifo_info.out_of_bounds) begin
                     res_status_in = STATUS_OUT_OF_BOUNDS;
                  end else begin
                     ram_rd_en = 1'b1;
                  end
               end
            end
         end
         BK_EXEC: begin
            if (cur_info_ff.kind == OP_READ) begin
               res_status_in = STATUS_PIXEL;
               res_pos_in    = word_pos;
               res_neg_in    = word_neg;
               if (total != '0) begin
                  div_start = 1'b1;
               end else begin
                  rsp_load  = out_free;
                  ld_status = STATUS_PIXEL;
                  ld_pos    = word_pos;
                  ld_neg    = word_neg;
                  ld_mean   = '0;
               end
            end else begin
               // The store write and the request's result go out in the same cycle.
               rsp_load  = out_free;
               ram_wr_en = out_free && !saturated;
               ld_status = saturated ? STATUS_SATURATED : STATUS_ACCEPTED;
               ld_pos    = '0;
               ld_neg    = '0;
               ld_mean   = '0;
            end
         end
         BK_DIV: begin
            if (div_done) begin
               res_mean_in = div_quotient;
            end
         end
         BK_POST: begin
            rsp_load = out_free;
         end
         default: rsp_load = 1'b0;
      endcase
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_neg_in    = rsp_neg_ff;
      rsp_mean_in   = rsp_mean_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ld_status;
         rsp_pos_in    = ld_pos;
         rsp_neg_in    = ld_neg;
         rsp_mean_in   = ld_mean;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_addr_ff  <= '0;
         clr_reply_ff <= 1'b0;
         ref_time_ff  <= '0;
         ref_taken_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_reply_ff <= clr_reply_in;
         ref_time_ff  <= ref_time_in;
         ref_taken_ff <= ref_taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_info_ff   <= cur_info_in;
      cur_addr_ff   <= cur_addr_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_neg_ff    <= res_neg_in;
      res_mean_ff   <= res_mean_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_neg_ff    <= rsp_neg_in;
      rsp_mean_ff   <= rsp_mean_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_positive_count = rsp_pos_ff;
   assign rsp_negative_count = rsp_neg_ff;
   assign rsp_mean_time      = rsp_mean_ff;

endmodule

`default_nettype wire

[hw/rtl/event_frame_accumulator.sv]
// Event frame accumulator: builds a per-pixel count and mean-time image.
// Request channel (req_*): command 0 adds one event at (x, y), command 1 reads a
// pixel, command 2 clears the whole frame; command 3 is taken and dropped.
// Response channel (rsp_*): one response per command 0, 1 or 2, in request order.
// csr_* writes the frame width (index 0) and height (index 1); write only when idle.
// A request is taken when req_valid is high and req_stall is low; likewise for rsp.
// The front registers and bounds-checks each request and hands it through a
// two-entry queue to the back, which owns the pixel store (one 80-bit RAM word
// per pixel, one read and one write port).
// With an idle block, an event or an out-of-bounds request passes the front's hold
// register and the queue before the back takes it. The back handles an event as a
// store read, then an update, and takes no new request before it is done with one.
// A read of a non-empty pixel adds a 48-step serial divide. A clear sweeps the
// whole store, one word a cycle. After reset the same sweep runs with req_stall
// high; no response follows it. A stalled response holds in the output register
// while the front keeps taking requests until the queue and the front's hold
// register are full.
`default_nettype none

module event_frame_accumulator
   import efa_pkg::*;
#(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic        [1:0]        req_command,
   input  wire logic        [TS_W-1:0]   req_timestamp,
   input  wire logic        [7:0]        req_x_coord,
   input  wire logic        [7:0]        req_y_coord,
   input  wire logic                     req_polarity,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic             [2:0]        rsp_status,
   output logic             [CNT_W-1:0]  rsp_positive_count,
   output logic             [CNT_W-1:0]  rsp_negative_count,
   output logic signed      [MEAN_W-1:0] rsp_mean_time,
   input  wire logic                     csr_write_enable,
   input  wire logic                     csr_index,
   input  wire logic        [CSR_W-1:0]  csr_write_data
);

   localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int QW     = $bits(op_info_type) + AW;

   logic              sweeping;
   logic              push;
   op_info_type       push_info;
   logic [AW-1:0]     push_addr;
   logic              fifo_full;
   logic              fifo_valid;
   logic              fifo_pop;
   logic [QW-1:0]     fifo_data;
   op_info_type       fifo_info;
   logic [AW-1:0]     fifo_addr;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;

   efa_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_timestamp    (req_timestamp),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_polarity     (req_polarity),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .sweeping         (sweeping),
      .fifo_full        (fifo_full),
      .push             (push),
      .push_info        (push_info),
      .push_addr        (push_addr)
   );

   efa_fifo #(
      .WIDTH (QW),
      .DEPTH (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_info, push_addr}),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .valid     (fifo_valid),
      .pop_data  (fifo_data)
   );

   assign fifo_info = fifo_data[QW-1:AW];
   assign fifo_addr = fifo_data[AW-1:0];

   efa_back #(
      .PIXELS (PIXELS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .fifo_valid         (fifo_valid),
      .fifo_info          (fifo_info),
      .fifo_addr          (fifo_addr),
      .fifo_pop           (fifo_pop),
      .sweeping           (sweeping),
      .ram_rd_en          (ram_rd_en),
      .ram_rd_addr        (ram_rd_addr),
      .ram_rd_data        (ram_rd_data),
      .ram_wr_en          (ram_wr_en),
      .ram_wr_addr        (ram_wr_addr),
      .ram_wr_data        (ram_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_positive_count (rsp_positive_count),
      .rsp_negative_count (rsp_negative_count),
      .rsp_mean_time      (rsp_mean_time)
   );

   efa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

[hw/rtl/efa_checker.sv]
`default_nettype none

module efa_checker
   import efa_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic        [2:0]        rsp_status,
   input wire logic        [CNT_W-1:0]  rsp_positive_count,
   input wire logic        [CNT_W-1:0]  rsp_negative_count,
   input wire logic signed [MEAN_W-1:0] rsp_mean_time
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_positive_count) && $stable(rsp_negative_count)
         && $stable(rsp_mean_time))
      else $error("response changed while stalled");

   // Only pixel data carries counts and a mean.
   a_plain_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_PIXEL |->
         rsp_positive_count == '0 && rsp_negative_count == '0 && rsp_mean_time == '0)
      else $error("non-pixel response has data fields");

   // An empty pixel reads back a zero mean.
   a_empty_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_PIXEL && rsp_positive_count == '0
         && rsp_negative_count == '0 |-> rsp_mean_time == '0)
      else $error("empty pixel with nonzero mean");

   // No pixel ever holds more than the count limit.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_PIXEL |->
         ({1'b0, rsp_positive_count} + {1'b0, rsp_negative_count}) <= COUNT_LIMIT)
      else $error("pixel count above limit");

   // Reset starts the store sweep: requests held off, no response pending.
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not sweeping after reset");

endmodule

bind event_frame_accumulator efa_checker u_efa_checker (.*);

`default_nettype wire
